/* sv/iprl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprl_pkg: shared types and constants of the route lookup engine
// Item layouts, queue entry, opcodes, status codes and default table sizes.
// ----------------------------------------------------------------------------
package iprl_pkg;

   // default table sizes
   localparam int DEF_ROUTE_ENTRIES    = 16;
   localparam int DEF_NEIGHBOR_ENTRIES = 16;
   localparam int DEF_PORT_COUNT       = 8;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // header length rules
   localparam logic [3:0] HL_MASK          = 4'h0f;
   localparam int         MIN_HEADER_BYTES = 20;

   // item kinds
   localparam logic [1:0] KIND_FORWARD    = 2'd0;
   localparam logic [1:0] KIND_ROUTE_WR   = 2'd1;
   localparam logic [1:0] KIND_NEIGHBOR_WR = 2'd2;
   localparam logic [1:0] KIND_PORT_WR    = 2'd3;

   // result status codes
   localparam logic [2:0] STATUS_FORWARDED  = 3'd0;
   localparam logic [2:0] STATUS_SHORT      = 3'd1;
   localparam logic [2:0] STATUS_NO_ROUTE   = 3'd2;
   localparam logic [2:0] STATUS_UNRESOLVED = 3'd3;
   localparam logic [2:0] STATUS_WRITTEN    = 3'd4;

   // classified operation carried through the queue
   typedef enum logic [2:0] {
      OP_FORWARD,
      OP_SHORT,
      OP_ROUTE_WR,
      OP_NEIGHBOR_WR,
      OP_PORT_WR
   } op_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_PICK,
      ST_READ
   } back_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  entry_index;
      logic [31:0] ip_address;
      logic [31:0] net_mask;
      logic [31:0] next_hop;
      logic [2:0]  port;
      logic [47:0] mac_address;
      logic [3:0]  header_words;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
      logic [2:0]  out_port;
      logic [3:0]  route_index;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  entry_index;
      logic [31:0] ip_address;
      logic [31:0] net_mask;
      logic [31:0] next_hop;
      logic [2:0]  port;
      logic [47:0] mac_address;
   } work_type;

endpackage

/* sv/iprl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprl_front: accept and classify
// Takes request beats, sorts them into operations and holds them in a short
// queue that the back end drains.
// ----------------------------------------------------------------------------
module iprl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iprl_pkg::req_type req_item,
   input  logic              pop,
   output logic              work_valid,
   output iprl_pkg::work_type work_item
);
   import iprl_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   work_type            classified;
   logic [3:0]          header_len;

   // classify the incoming beat
   always_comb begin
      header_len             = req_item.header_words & HL_MASK;
      classified.entry_index = req_item.entry_index;
      classified.ip_address  = req_item.ip_address;
      classified.net_mask    = req_item.net_mask;
      classified.next_hop    = req_item.next_hop;
      classified.port        = req_item.port;
      classified.mac_address = req_item.mac_address;
      case (req_item.kind)
         KIND_ROUTE_WR:    classified.op = OP_ROUTE_WR;
         KIND_NEIGHBOR_WR: classified.op = OP_NEIGHBOR_WR;
         KIND_PORT_WR:     classified.op = OP_PORT_WR;
         default: begin
            if ({2'b00, header_len, 2'b00} < 8'(MIN_HEADER_BYTES)) begin
               classified.op = OP_SHORT;
            end else begin
               classified.op = OP_FORWARD;
            end
         end
      endcase
   end

   // queue pointers and fill level
   assign busy       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign work_valid = (count_ff != '0);
   assign work_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill level beyond depth");

   // back end only drains a queue that holds something
   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

/* sv/iprl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprl_back: table update and lookup sequencer
// Applies table writes, and runs a packet through match, priority pick and
// entry read, producing one registered response beat per operation.
// ----------------------------------------------------------------------------
module iprl_back #(
   parameter int ROUTE_ENTRIES    = iprl_pkg::DEF_ROUTE_ENTRIES,
   parameter int NEIGHBOR_ENTRIES = iprl_pkg::DEF_NEIGHBOR_ENTRIES,
   parameter int PORT_COUNT       = iprl_pkg::DEF_PORT_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   input  iprl_pkg::work_type work_item,
   output logic               pop,
   output logic               rsp_strobe,
   output iprl_pkg::rsp_type  rsp_item
);
   import iprl_pkg::*;

   localparam int RIDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int NIDX_W = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
   localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

   // route table
   logic [31:0]              rt_network_ff [ROUTE_ENTRIES];
   logic [31:0]              rt_mask_ff    [ROUTE_ENTRIES];
   logic [31:0]              rt_gateway_ff [ROUTE_ENTRIES];
   logic [2:0]               rt_port_ff    [ROUTE_ENTRIES];
   logic [47:0]              rt_gw_mac_ff  [ROUTE_ENTRIES];
   logic [ROUTE_ENTRIES-1:0] rt_valid_ff;

   // neighbor cache
   logic [31:0]                 nb_ip_ff  [NEIGHBOR_ENTRIES];
   logic [47:0]                 nb_mac_ff [NEIGHBOR_ENTRIES];
   logic [NEIGHBOR_ENTRIES-1:0] nb_valid_ff;

   // port addresses
   logic [47:0] pm_mac_ff [PORT_COUNT];

   // sequencer and lookup registers
   back_state_type              state_ff, state_in;
   logic [31:0]                 dst_ff, dst_in;
   logic [ROUTE_ENTRIES-1:0]    rt_hit_ff, rt_hit_in;
   logic [NEIGHBOR_ENTRIES-1:0] nb_hit_ff, nb_hit_in;
   logic [RIDX_W-1:0]           r_idx_ff, r_idx_in;
   logic                        r_found_ff, r_found_in;
   logic [NIDX_W-1:0]           n_idx_ff, n_idx_in;
   logic                        n_found_ff, n_found_in;
   logic                        strobe_ff, strobe_in;
   rsp_type                     rsp_ff, rsp_in;

   // write decode
   logic                rt_we, nb_we, pm_we;
   logic [RIDX_W+3:0]   rt_slot_ext;
   logic [NIDX_W+3:0]   nb_slot_ext;
   logic [PIDX_W+2:0]   pm_slot_ext;
   logic [RIDX_W-1:0]   rt_slot;
   logic [NIDX_W-1:0]   nb_slot;
   logic [PIDX_W-1:0]   pm_slot;

   // read side of the selected route
   logic [2:0]          sel_port;
   logic [PIDX_W+2:0]   sel_port_ext;
   logic [47:0]         sel_src_mac;
   logic [RIDX_W+3:0]   r_idx_ext;

   assign rt_slot_ext = {{RIDX_W{1'b0}}, work_item.entry_index};
   assign nb_slot_ext = {{NIDX_W{1'b0}}, work_item.entry_index};
   assign pm_slot_ext = {{PIDX_W{1'b0}}, work_item.port};
   assign rt_slot     = rt_slot_ext[RIDX_W-1:0];
   assign nb_slot     = nb_slot_ext[NIDX_W-1:0];
   assign pm_slot     = pm_slot_ext[PIDX_W-1:0];

   // matched route fields and its egress port address
   always_comb begin
      sel_port     = rt_port_ff[r_idx_ff];
      sel_port_ext = {{PIDX_W{1'b0}}, sel_port};
      if (32'(sel_port) < PORT_COUNT) begin
         sel_src_mac = pm_mac_ff[sel_port_ext[PIDX_W-1:0]];
      end else begin
         sel_src_mac = '0;
      end
      r_idx_ext = {4'b0000, r_idx_ff};
   end

   // sequencer: next state, table writes and response
   always_comb begin
      state_in   = state_ff;
      dst_in     = dst_ff;
      rt_hit_in  = rt_hit_ff;
      nb_hit_in  = nb_hit_ff;
      r_idx_in   = r_idx_ff;
      r_found_in = r_found_ff;
      n_idx_in   = n_idx_ff;
      n_found_in = n_found_ff;
      strobe_in  = 1'b0;
      rsp_in     = '0;
      pop        = 1'b0;
      rt_we      = 1'b0;
      nb_we      = 1'b0;
      pm_we      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (work_valid) begin
               pop       = 1'b1;
               strobe_in = 1'b1;
               case (work_item.op)
                  OP_FORWARD: begin
                     strobe_in = 1'b0;
                     dst_in    = work_item.ip_address;
                     state_in  = ST_MATCH;
                  end
                  OP_SHORT: begin
                     rsp_in.status = STATUS_SHORT;
                  end
                  OP_ROUTE_WR: begin
                     rt_we         = (32'(work_item.entry_index) < ROUTE_ENTRIES);
                     rsp_in.status = STATUS_WRITTEN;
                  end
                  OP_NEIGHBOR_WR: begin
                     nb_we         = (32'(work_item.entry_index) < NEIGHBOR_ENTRIES);
                     rsp_in.status = STATUS_WRITTEN;
                  end
                  OP_PORT_WR: begin
                     pm_we         = (32'(work_item.port) < PORT_COUNT);
                     rsp_in.status = STATUS_WRITTEN;
                  end
                  default: begin
                     rsp_in.status = STATUS_WRITTEN;
                  end
               endcase
            end
         end
         // compare every entry against the destination
         ST_MATCH: begin
            for (int i = 0; i < ROUTE_ENTRIES; i++) begin
               rt_hit_in[i] = rt_valid_ff[i] && ((dst_ff & rt_mask_ff[i]) == rt_network_ff[i]);
            end
            for (int j = 0; j < NEIGHBOR_ENTRIES; j++) begin
               nb_hit_in[j] = nb_valid_ff[j] && (nb_ip_ff[j] == dst_ff);
            end
            state_in = ST_PICK;
         end
         // lowest-numbered hit wins
         ST_PICK: begin
            r_found_in = 1'b0;
            r_idx_in   = '0;
            for (int i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
               if (rt_hit_ff[i]) begin
                  r_found_in = 1'b1;
                  r_idx_in   = RIDX_W'(i);
               end
            end
            n_found_in = 1'b0;
            n_idx_in   = '0;
            for (int j = NEIGHBOR_ENTRIES - 1; j >= 0; j--) begin
               if (nb_hit_ff[j]) begin
                  n_found_in = 1'b1;
                  n_idx_in   = NIDX_W'(j);
               end
            end
            state_in = ST_READ;
         end
         // read the chosen entries and form the response
         ST_READ: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
            if (!r_found_ff) begin
               rsp_in.status = STATUS_NO_ROUTE;
            end else begin
               rsp_in.src_mac     = sel_src_mac;
               rsp_in.out_port    = sel_port;
               rsp_in.route_index = r_idx_ext[3:0];
               if (rt_gateway_ff[r_idx_ff] != '0) begin
                  rsp_in.status   = STATUS_FORWARDED;
                  rsp_in.dest_mac = rt_gw_mac_ff[r_idx_ff];
               end else if (n_found_ff) begin
                  rsp_in.status   = STATUS_FORWARDED;
                  rsp_in.dest_mac = nb_mac_ff[n_idx_ff];
               end else begin
                  rsp_in.status   = STATUS_UNRESOLVED;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state, valid bits and port addresses
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         strobe_ff   <= 1'b0;
         rt_valid_ff <= '0;
         nb_valid_ff <= '0;
         for (int k = 0; k < PORT_COUNT; k++) begin
            pm_mac_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (rt_we) begin
            rt_valid_ff[rt_slot] <= 1'b1;
         end
         if (nb_we) begin
            nb_valid_ff[nb_slot] <= 1'b1;
         end
         if (pm_we) begin
            pm_mac_ff[pm_slot] <= work_item.mac_address;
         end
      end
   end

   // table payload and lookup pipeline registers
   always_ff @(posedge clock) begin
      dst_ff     <= dst_in;
      rt_hit_ff  <= rt_hit_in;
      nb_hit_ff  <= nb_hit_in;
      r_idx_ff   <= r_idx_in;
      r_found_ff <= r_found_in;
      n_idx_ff   <= n_idx_in;
      n_found_ff <= n_found_in;
      rsp_ff     <= rsp_in;
      if (rt_we) begin
         rt_network_ff[rt_slot] <= work_item.ip_address;
         rt_mask_ff[rt_slot]    <= work_item.net_mask;
         rt_gateway_ff[rt_slot] <= work_item.next_hop;
         rt_port_ff[rt_slot]    <= work_item.port;
         rt_gw_mac_ff[rt_slot]  <= work_item.mac_address;
      end
      if (nb_we) begin
         nb_ip_ff[nb_slot]  <= work_item.ip_address;
         nb_mac_ff[nb_slot] <= work_item.mac_address;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // a response beat follows only a direct operation or the read step
   assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_READ))
      else $error("response beat out of sequence");

   // a lookup always proceeds from match to pick
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MATCH |=> state_ff == ST_PICK)
      else $error("match step not followed by pick");

   // a missed route carries no addresses
   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_ff.status == STATUS_NO_ROUTE) |->
         (rsp_ff.dest_mac == '0 && rsp_ff.src_mac == '0 && rsp_ff.out_port == '0))
      else $error("no-route response with nonzero fields");

endmodule

/* sv/ip_route_lookup_mac_rewrite.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_route_lookup_mac_rewrite: IPv4 forwarding decision engine
// Route table, neighbor cache and port addresses with first-match lookup and
// frame address rewrite.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; it goes into a
// two-deep queue, and busy is high only while that queue is full. Each beat
// produces exactly one response, shown for one cycle with rsp_strobe, in
// request order; the receiver cannot stall it. Table writes and short headers
// are answered from the back end's idle state, so their response passes only
// through the queue and the response register. A packet lookup steps through
// match, priority pick and entry read before its response is registered, and
// the back end pops no further beat until the read step is done; that sequence
// sets the sustained rate. Route and neighbor valid bits clear and port
// addresses read zero straight out of reset, with no clearing pass.
module ip_route_lookup_mac_rewrite #(
   parameter int ROUTE_ENTRIES    = iprl_pkg::DEF_ROUTE_ENTRIES,
   parameter int NEIGHBOR_ENTRIES = iprl_pkg::DEF_NEIGHBOR_ENTRIES,
   parameter int PORT_COUNT       = iprl_pkg::DEF_PORT_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iprl_pkg::req_type req_item,
   output logic              rsp_strobe,
   output iprl_pkg::rsp_type rsp_item
);
   import iprl_pkg::*;

   logic     work_valid;
   logic     pop;
   work_type work_item;

   // accept and classify
   iprl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .pop        (pop),
      .work_valid (work_valid),
      .work_item  (work_item)
   );

   // tables and lookup
   iprl_back #(
      .ROUTE_ENTRIES    (ROUTE_ENTRIES),
      .NEIGHBOR_ENTRIES (NEIGHBOR_ENTRIES),
      .PORT_COUNT       (PORT_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_item  (work_item),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

/* tb/ip_route_lookup_mac_rewrite_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_route_lookup_mac_rewrite_checker: forwarding decision scoreboard
// Watches request and response beats of the route lookup engine, keeps its own
// route table, neighbor cache and port addresses, predicts each decision and
// compares every response beat with the oldest predicted decision.
// ----------------------------------------------------------------------------
module ip_route_lookup_mac_rewrite_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  iprl_pkg::req_type req_item,
   input  logic              rsp_strobe,
   input  iprl_pkg::rsp_type rsp_item,
   output int                mismatch_count,
   output int                decisions_pending
);
   import iprl_pkg::*;

   // shadow tables
   logic [31:0] route_net    [DEF_ROUTE_ENTRIES];
   logic [31:0] route_mask   [DEF_ROUTE_ENTRIES];
   logic [31:0] route_gw     [DEF_ROUTE_ENTRIES];
   logic [2:0]  route_port   [DEF_ROUTE_ENTRIES];
   logic [47:0] route_gw_mac [DEF_ROUTE_ENTRIES];
   logic        route_live   [DEF_ROUTE_ENTRIES];
   logic [31:0] neighbor_ip   [DEF_NEIGHBOR_ENTRIES];
   logic [47:0] neighbor_mac  [DEF_NEIGHBOR_ENTRIES];
   logic        neighbor_live [DEF_NEIGHBOR_ENTRIES];
   logic [47:0] port_mac [DEF_PORT_COUNT];

   rsp_type expected_decisions [$];
   rsp_type oldest_decision;

   // apply one request beat to the shadow tables and work out its response
   function automatic rsp_type forward_decision(input req_type beat);
      rsp_type    d;
      int         hit;
      logic [2:0] egress;
      d   = '0;
      hit = -1;
      case (beat.kind)
         KIND_ROUTE_WR: begin
            if (beat.entry_index < DEF_ROUTE_ENTRIES) begin
               route_net[beat.entry_index]    = beat.ip_address;
               route_mask[beat.entry_index]   = beat.net_mask;
               route_gw[beat.entry_index]     = beat.next_hop;
               route_port[beat.entry_index]   = beat.port;
               route_gw_mac[beat.entry_index] = beat.mac_address;
               route_live[beat.entry_index]   = 1'b1;
            end
            d.status = STATUS_WRITTEN;
         end
         KIND_NEIGHBOR_WR: begin
            if (beat.entry_index < DEF_NEIGHBOR_ENTRIES) begin
               neighbor_ip[beat.entry_index]   = beat.ip_address;
               neighbor_mac[beat.entry_index]  = beat.mac_address;
               neighbor_live[beat.entry_index] = 1'b1;
            end
            d.status = STATUS_WRITTEN;
         end
         KIND_PORT_WR: begin
            if (beat.port < DEF_PORT_COUNT)
               port_mac[beat.port] = beat.mac_address;
            d.status = STATUS_WRITTEN;
         end
         // packet forward
         default: begin
            if ((beat.header_words & HL_MASK) * 4 < MIN_HEADER_BYTES) begin
               d.status = STATUS_SHORT;
            end else begin
               // lowest valid route whose masked destination equals its network
               for (int i = 0; i < DEF_ROUTE_ENTRIES; i++)
                  if (hit < 0 && route_live[i] &&
                      (beat.ip_address & route_mask[i]) == route_net[i])
                     hit = i;
               if (hit < 0) begin
                  d.status = STATUS_NO_ROUTE;
               end else begin
                  egress        = route_port[hit];
                  d.route_index = 4'(hit);
                  d.out_port    = egress;
                  d.src_mac     = (egress < DEF_PORT_COUNT) ? port_mac[egress] : '0;
                  if (route_gw[hit] != '0) begin
                     d.status   = STATUS_FORWARDED;
                     d.dest_mac = route_gw_mac[hit];
                  end else begin
                     // direct route: first valid neighbor with the same address
                     d.status = STATUS_UNRESOLVED;
                     for (int i = 0; i < DEF_NEIGHBOR_ENTRIES; i++)
                        if (d.status == STATUS_UNRESOLVED && neighbor_live[i] &&
                            neighbor_ip[i] == beat.ip_address) begin
                           d.status   = STATUS_FORWARDED;
                           d.dest_mac = neighbor_mac[i];
                        end
                  end
               end
            end
         end
      endcase
      return d;
   endfunction

   // compare response beats, then record the decision of an accepted request
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEF_ROUTE_ENTRIES; i++) route_live[i] = 1'b0;
         for (int i = 0; i < DEF_NEIGHBOR_ENTRIES; i++) neighbor_live[i] = 1'b0;
         for (int i = 0; i < DEF_PORT_COUNT; i++) port_mac[i] = '0;
         expected_decisions.delete();
         mismatch_count = 0;
         decisions_pending <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_decisions.size() == 0) begin
               $error("response beat with no request waiting: status %0d",
                      rsp_item.status);
               mismatch_count++;
            end else begin
               oldest_decision = expected_decisions.pop_front();
               if (rsp_item.status !== oldest_decision.status) begin
                  $error("status: expected %0d, actual %0d",
                         oldest_decision.status, rsp_item.status);
                  mismatch_count++;
               end
               if (rsp_item.dest_mac !== oldest_decision.dest_mac) begin
                  $error("dest_mac: expected %h, actual %h",
                         oldest_decision.dest_mac, rsp_item.dest_mac);
                  mismatch_count++;
               end
               if (rsp_item.src_mac !== oldest_decision.src_mac) begin
                  $error("src_mac: expected %h, actual %h",
                         oldest_decision.src_mac, rsp_item.src_mac);
                  mismatch_count++;
               end
               if (rsp_item.out_port !== oldest_decision.out_port) begin
                  $error("out_port: expected %0d, actual %0d",
                         oldest_decision.out_port, rsp_item.out_port);
                  mismatch_count++;
               end
               if (rsp_item.route_index !== oldest_decision.route_index) begin
                  $error("route_index: expected %0d, actual %0d",
                         oldest_decision.route_index, rsp_item.route_index);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            expected_decisions.push_back(forward_decision(req_item));
         decisions_pending <= expected_decisions.size();
      end
   end

endmodule

/* tb/tb_ip_route_lookup_mac_rewrite.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_route_lookup_mac_rewrite: testbench of the route lookup engine
// Drives a directed set of table writes and lookups, then random beats built
// around a small pool of hot addresses so routes and neighbors really match,
// under three sender idling profiles. The checker scores every response.
// ----------------------------------------------------------------------------
module tb_ip_route_lookup_mac_rewrite;
   import iprl_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      mismatch_count;
   int      decisions_pending;

   logic [31:0] hot_addr [8];
   int          idle_profile [3] = '{20, 50, 0};
   int          drain_guard;

   always #4 clock = ~clock;

   ip_route_lookup_mac_rewrite u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   ip_route_lookup_mac_rewrite_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_item          (req_item),
      .rsp_strobe        (rsp_strobe),
      .rsp_item          (rsp_item),
      .mismatch_count    (mismatch_count),
      .decisions_pending (decisions_pending)
   );

   // run time limit
   initial begin
      #400_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [47:0] random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // every field random, so fields a kind ignores still carry noise
   function automatic req_type noise_beat();
      req_type b;
      b.kind         = 2'($urandom);
      b.entry_index  = 4'($urandom);
      b.ip_address   = $urandom;
      b.net_mask     = $urandom;
      b.next_hop     = $urandom;
      b.port         = 3'($urandom);
      b.mac_address  = random_mac();
      b.header_words = 4'($urandom);
      return b;
   endfunction

   function automatic req_type lookup_beat(input logic [31:0] dst, input logic [3:0] hl);
      req_type b;
      b              = noise_beat();
      b.kind         = KIND_FORWARD;
      b.ip_address   = dst;
      b.header_words = hl;
      return b;
   endfunction

   function automatic req_type route_beat(input logic [3:0] slot, input logic [31:0] net,
                                          input logic [31:0] mask, input logic [31:0] hop,
                                          input logic [2:0] egress, input logic [47:0] mac);
      req_type b;
      b             = noise_beat();
      b.kind        = KIND_ROUTE_WR;
      b.entry_index = slot;
      b.ip_address  = net;
      b.net_mask    = mask;
      b.next_hop    = hop;
      b.port        = egress;
      b.mac_address = mac;
      return b;
   endfunction

   function automatic req_type neighbor_beat(input logic [3:0] slot, input logic [31:0] addr,
                                             input logic [47:0] mac);
      req_type b;
      b             = noise_beat();
      b.kind        = KIND_NEIGHBOR_WR;
      b.entry_index = slot;
      b.ip_address  = addr;
      b.mac_address = mac;
      return b;
   endfunction

   function automatic req_type port_beat(input logic [2:0] egress, input logic [47:0] mac);
      req_type b;
      b             = noise_beat();
      b.kind        = KIND_PORT_WR;
      b.port        = egress;
      b.mac_address = mac;
      return b;
   endfunction

   // random beat, mostly aimed at the hot address pool
   function automatic req_type random_beat();
      int          roll;
      int          plen;
      logic [31:0] mask;
      logic [31:0] addr;
      logic [31:0] hop;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 5)
         hot_addr[$urandom_range(0, 7)] = $urandom;
      addr = hot_addr[$urandom_range(0, 7)];
      if (roll < 50) begin
         case ($urandom_range(0, 2))
            1:       addr = addr ^ ($urandom & 32'h0000_00ff);
            2:       addr = $urandom;
            default: ;
         endcase
         return lookup_beat(addr, ($urandom_range(0, 99) < 85) ?
                                  4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4)));
      end else if (roll < 70) begin
         plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(16, 32);
         mask = (plen == 0) ? 32'h0 : 32'hffff_ffff << (32 - plen);
         case ($urandom_range(0, 3))
            2:       hop = $urandom;
            3:       hop = 32'hffff_ffff;
            default: hop = '0;
         endcase
         return route_beat(4'($urandom), ($urandom_range(0, 99) < 85) ? (addr & mask) : $urandom,
                           mask, hop, 3'($urandom), random_mac());
      end else if (roll < 88) begin
         if ($urandom_range(0, 99) < 30) begin
            addr = $urandom;
            hot_addr[$urandom_range(0, 7)] = addr;
         end
         return neighbor_beat(4'($urandom), addr, random_mac());
      end else begin
         return port_beat(3'($urandom), random_mac());
      end
   endfunction

   // hold a beat on the request port until the block takes it
   task automatic send_beat(input req_type beat, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= beat;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      foreach (hot_addr[i]) hot_addr[i] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tables, short headers, table writes, lookup cases
      send_beat(lookup_beat(32'h0a00_0001, 4'd5), 20);
      send_beat(lookup_beat(32'h0a00_0001, 4'd0), 20);
      send_beat(lookup_beat(32'h0a00_0001, 4'd4), 20);
      send_beat(port_beat(3'd0, 48'hffff_ffff_ffff), 20);
      send_beat(port_beat(3'd7, 48'h0123_4567_89ab), 20);
      send_beat(port_beat(3'd3, 48'ha5a5_a5a5_a5a5), 20);
      // default direct route in the last slot
      send_beat(route_beat(4'd15, 32'h0, 32'h0, 32'h0, 3'd7, 48'h0), 20);
      // gateway route in slot 0
      send_beat(route_beat(4'd0, 32'h0a00_0000, 32'hffff_ff00, 32'hffff_ffff, 3'd0,
                           48'hffff_ffff_ffff), 20);
      // network bits outside the mask, can never match
      send_beat(route_beat(4'd1, 32'hc0a8_0101, 32'hffff_0000, 32'h1, 3'd3,
                           48'h5a5a_5a5a_5a5a), 20);
      send_beat(neighbor_beat(4'd15, 32'hc0a8_0101, 48'h0000_0000_0001), 20);
      send_beat(neighbor_beat(4'd0, 32'hffff_ffff, 48'hffff_ffff_ffff), 20);
      // same address in a lower slot wins
      send_beat(neighbor_beat(4'd3, 32'hc0a8_0101, 48'h2222_2222_2222), 20);
      send_beat(lookup_beat(32'h0a00_00ff, 4'd15), 20);
      send_beat(lookup_beat(32'hc0a8_0101, 4'd5), 20);
      send_beat(lookup_beat(32'hffff_ffff, 4'd5), 20);
      send_beat(lookup_beat(32'h0000_0000, 4'd6), 20);
      send_beat(lookup_beat(32'hc0a8_0101, 4'd4), 20);
      // host route takes priority over the default route
      send_beat(route_beat(4'd0, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 3'd3,
                           48'h0), 20);
      send_beat(lookup_beat(32'hffff_ffff, 4'd15), 20);
      send_beat(lookup_beat(32'h0a00_0001, 4'd5), 20);

      // random beats under each idling profile
      foreach (idle_profile[p])
         repeat (400) send_beat(random_beat(), idle_profile[p]);
      start <= 1'b0;

      // wait for outstanding responses, with a guard on the wait, then check the result
      drain_guard = 0;
      do begin
         @(posedge clock);
         drain_guard++;
      end while (decisions_pending != 0 && drain_guard < 2000);
      repeat (8) @(posedge clock);

      if (decisions_pending != 0)
         $error("%0d expected responses never arrived", decisions_pending);
      if (mismatch_count == 0 && decisions_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
sv/iprl_pkg.sv
sv/iprl_front.sv
sv/iprl_back.sv
sv/ip_route_lookup_mac_rewrite.sv
tb/ip_route_lookup_mac_rewrite_checker.sv
tb/tb_ip_route_lookup_mac_rewrite.sv
